@@ design/srlv_pkg.sv @@
// Package with the types and constants of the SAM record line validator.
package srlv_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned ColW    = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 64;
  localparam int unsigned MapW    = 256;

  localparam logic [ByteW-1:0] ChAt   = 8'h40;
  localparam logic [ByteW-1:0] ChNl   = 8'h0A;
  localparam logic [ByteW-1:0] ChTab  = 8'h09;
  localparam logic [ByteW-1:0] ChDash = 8'h2D;
  localparam logic [ByteW-1:0] ChSp   = 8'h20;
  localparam logic [ByteW-1:0] ChCr   = 8'h0D;
  localparam logic [ByteW-1:0] Ch0    = 8'h30;
  localparam logic [ByteW-1:0] Ch9    = 8'h39;

  localparam logic [CfgIdxW-1:0] RegSeq0  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSeq1  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSeq2  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSeq3  = 2'd3;

  localparam logic [CfgW-1:0] Seq0Rst = 64'd0;
  localparam logic [CfgW-1:0] Seq1Rst = 64'd215163009582786974;
  localparam logic [CfgW-1:0] Seq2Rst = 64'd0;
  localparam logic [CfgW-1:0] Seq3Rst = 64'd0;

  localparam logic [ColW-1:0] ColQname = 4'd1;
  localparam logic [ColW-1:0] ColFlag  = 4'd2;
  localparam logic [ColW-1:0] ColRname = 4'd3;
  localparam logic [ColW-1:0] ColPos   = 4'd4;
  localparam logic [ColW-1:0] ColMapq  = 4'd5;
  localparam logic [ColW-1:0] ColCigar = 4'd6;
  localparam logic [ColW-1:0] ColRnext = 4'd7;
  localparam logic [ColW-1:0] ColPnext = 4'd8;
  localparam logic [ColW-1:0] ColTlen  = 4'd9;
  localparam logic [ColW-1:0] ColSeq   = 4'd10;
  localparam logic [ColW-1:0] ColQual  = 4'd11;
  localparam logic [ColW-1:0] ColLater = 4'd12;

  typedef enum logic [3:0] {
    PhStart  = 4'b0001,
    PhHeader = 4'b0010,
    PhRecord = 4'b0100,
    PhDone   = 4'b1000
  } srlv_phase_e;

  typedef struct packed {
    logic ws;
    logic dig;
    logic dash;
    logic tab;
    logic nl;
    logic at;
    logic seq;
  } srlv_class_t;

  typedef struct packed {
    logic have;
    logic verdict;
  } srlv_res_t;

endpackage

@@ design/sam_record_line_validator.sv @@
// Top level of the SAM record line validator.
// Bytes of a text buffer enter on the slave stream, one per item: tdata carries
// the byte and tlast marks the final byte of the buffer. Each buffer yields
// exactly one verdict item on the master stream, where bit 0 of tdata is 1 when
// the buffer looks like SAM alignment data. The verdict is given at the first
// bad byte, at the newline closing the first record line, or at the last byte.
// The SEQ character set is a 256-bit bitmap written as four 64-bit registers
// through the configuration port; the user must write them only while the
// block is idle; the block does not enforce it. A byte is captured in an input
// register and judged there; its verdict is stored in a result register and
// offered from it. One byte is accepted every cycle unless the stall below
// holds them back; the two registers let bytes flow on while a verdict waits.
// When the receiver stalls with a verdict pending, a byte that yields another
// verdict waits in the input register and holds back further bytes.
// Reset empties both registers, returns the parser to the start of a buffer
// and loads the default SEQ bitmap of IUPAC letters in both cases.
module sam_record_line_validator
  import srlv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_addr_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,  // [7:0] byte_value
  input  logic               s_axis_tlast_i,  // last_byte
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [7:0]         m_axis_tdata_o   // [0] is_valid, [7:1] zero
);

  logic [CfgW-1:0]  seq0_q, seq1_q, seq2_q, seq3_q;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             in_last_q;
  logic             out_valid_q;
  logic             out_data_q;
  logic             advance;
  srlv_class_t      byte_class;
  srlv_res_t        res;
  srlv_phase_e      phase;
  logic [ColW-1:0]  col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq0_q <= Seq0Rst;
      seq1_q <= Seq1Rst;
      seq2_q <= Seq2Rst;
      seq3_q <= Seq3Rst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        RegSeq0: seq0_q <= cfg_data_i;
        RegSeq1: seq1_q <= cfg_data_i;
        RegSeq2: seq2_q <= cfg_data_i;
        RegSeq3: seq3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  srlv_classify u_classify (
    .byte_i    (in_byte_q),
    .seq_map_i ({seq3_q, seq2_q, seq1_q, seq0_q}),
    .class_o   (byte_class)
  );

  srlv_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .class_i   (byte_class),
    .last_i    (in_last_q),
    .res_o     (res),
    .phase_o   (phase),
    .col_o     (col)
  );

  assign advance         = in_valid_q && (!res.have || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.have) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.have) begin
      out_data_q <= res.verdict;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_data_q};

  // A new verdict never overwrites one that the receiver has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && res.have && out_valid_q && !m_axis_tready_i))
    else $error("verdict overwritten while stalled");

  // A pending verdict keeps its value until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_data_q))
    else $error("pending verdict changed");

  // The last byte of a buffer returns the parser to the start of a buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> phase == PhStart && col == ColQname)
    else $error("parser not cleared after last byte");

  // A byte is only consumed when it is held in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |-> in_valid_q)
    else $error("advance without a held byte");

endmodule

@@ design/srlv_classify.sv @@
// Byte classifier: whitespace, digit, dash, tab, newline, '@' and SEQ bitmap membership.
module srlv_classify
  import srlv_pkg::*;
(
  input  logic [ByteW-1:0] byte_i,
  input  logic [MapW-1:0]  seq_map_i,
  output srlv_class_t      class_o
);

  always_comb begin
    class_o.ws   = (byte_i == ChSp) || (byte_i inside {[ChTab:ChCr]});
    class_o.dig  = byte_i inside {[Ch0:Ch9]};
    class_o.dash = (byte_i == ChDash);
    class_o.tab  = (byte_i == ChTab);
    class_o.nl   = (byte_i == ChNl);
    class_o.at   = (byte_i == ChAt);
    class_o.seq  = seq_map_i[byte_i];
  end

endmodule

@@ design/srlv_step.sv @@
// Parser state and the per-byte verdict logic of the validator.
module srlv_step
  import srlv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  srlv_class_t class_i,
  input  logic        last_i,
  output srlv_res_t   res_o,
  output srlv_phase_e phase_o,
  output logic [ColW-1:0] col_o
);

  srlv_phase_e     phase_q, phase_d;
  logic [ColW-1:0] col_q, col_d;
  logic            prev_ws_q, prev_ws_d;
  logic            byte_ok;

  always_comb begin
    case (col_q)
      ColQname, ColRname, ColCigar, ColRnext, ColQual: byte_ok = !class_i.ws;
      ColFlag, ColPos, ColMapq, ColPnext:              byte_ok = class_i.dig;
      ColTlen:                                         byte_ok = class_i.dig || class_i.dash;
      ColSeq:                                          byte_ok = class_i.seq;
      default:                                         byte_ok = 1'b1;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    col_d       = col_q;
    prev_ws_d   = prev_ws_q;
    res_o       = '0;
    if (phase_q != PhDone) begin
      if (phase_q == PhStart && class_i.at) begin
        phase_d = PhHeader;
      end else if (phase_q == PhHeader) begin
        if (class_i.nl) begin
          phase_d = PhStart;
        end
      end else begin
        phase_d = PhRecord;
        if (class_i.nl) begin
          res_o.have    = 1'b1;
          res_o.verdict = (col_q >= ColQual);
        end else if (class_i.tab) begin
          if (prev_ws_q) begin
            res_o.have = 1'b1;
          end else if (col_q < ColLater) begin
            col_d = col_q + 1'b1;
          end
        end else if (!byte_ok) begin
          res_o.have = 1'b1;
        end
        if (res_o.have) begin
          phase_d = PhDone;
        end
      end
      prev_ws_d = class_i.ws;
      if (last_i && !res_o.have) begin
        res_o.have    = 1'b1;
        res_o.verdict = 1'b1;
      end
    end
    if (last_i) begin
      phase_d   = PhStart;
      col_d     = ColQname;
      prev_ws_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhStart;
      col_q     <= ColQname;
      prev_ws_q <= 1'b1;
    end else if (advance_i) begin
      phase_q   <= phase_d;
      col_q     <= col_d;
      prev_ws_q <= prev_ws_d;
    end
  end

  assign phase_o = phase_q;
  assign col_o   = col_q;

endmodule
